FILE: rtl/ghp_pkg.sv
// Shared types and constants for the generational handle pool.
// Used by ghp_front, ghp_back and generational_handle_pool; depends on nothing.
package ghp_pkg;

	localparam int SLOTS_DEF      = 1024;
	localparam int ITEM_WIDTH_DEF = 32;

	localparam int LIMIT_W  = 11;
	localparam int COUNT_W  = 11;
	localparam int HANDLE_W = 32;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = 16;
	localparam int GEN_W    = 15;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;
	localparam logic [IDX_W-1:0]   IDX_NULL    = 16'hffff;
	localparam logic [GEN_W-1:0]   GEN_WRAP    = 15'h7fff;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_STALE = 2'd2;

	typedef enum logic [1:0] {
		OPC_ADD    = 2'd0,
		OPC_REMOVE = 2'd1,
		OPC_GET    = 2'd2,
		OPC_NOP    = 2'd3
	} opcode_t;

	// Classified request as it travels from front to back
	typedef struct packed {
		opcode_t           kind;
		logic              idx_in_range;
		logic [IDX_W-1:0]  idx;
		logic [GEN_W-1:0]  gen;
		logic [DATA_W-1:0] data;
	} req_t;

	// Slot table entry: live entries hold their generation, freed ones also link on
	typedef struct packed {
		logic              inv;
		logic [GEN_W-1:0]  gen;
		logic [IDX_W-1:0]  link;
	} slot_ent_t;

endpackage

FILE: rtl/ghp_front.sv
// Front end of the handle pool: decodes incoming requests and queues them.
// Depends on ghp_pkg; feeds ghp_back through a two-entry queue.
module ghp_front #(
	parameter int SLOTS = ghp_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    opcode,
	input  logic [ghp_pkg::HANDLE_W-1:0]  handle_in,
	input  logic [ghp_pkg::DATA_W-1:0]    item_data,
	output logic                          req_valid,
	input  logic                          req_ready,
	output ghp_pkg::req_t                 req
);
	import ghp_pkg::*;

	req_t       q_mem_q [2];
	logic [1:0] q_cnt_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	req_t       req_new;
	logic       push;
	logic       pop;

	always_comb begin
		req_new.kind         = opcode_t'(opcode);
		req_new.idx          = handle_in[IDX_W-1:0];
		req_new.gen          = handle_in[IDX_W+GEN_W-1:IDX_W];
		req_new.data         = item_data;
		// bit 31 of the handle plays no part in any check
		req_new.idx_in_range = {1'b0, handle_in[IDX_W-1:0]} < (IDX_W+1)'(SLOTS);
	end

	assign in_ready  = q_cnt_q != 2'd2;
	assign req_valid = q_cnt_q != 2'd0;
	assign req       = q_mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_cnt_q  <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			priority if (push && !pop) begin
				q_cnt_q <= q_cnt_q + 2'd1;
			end else if (pop && !push) begin
				q_cnt_q <= q_cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_ptr_q] <= req_new;
	end

endmodule

FILE: rtl/ghp_back.sv
// Back end of the handle pool: slot table, item store, free list and counts.
// Depends on ghp_pkg; takes classified requests from ghp_front.
module ghp_back #(
	parameter int SLOTS      = ghp_pkg::SLOTS_DEF,
	parameter int ITEM_WIDTH = ghp_pkg::ITEM_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ghp_pkg::LIMIT_W-1:0]   slot_limit,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  ghp_pkg::req_t                 req,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ghp_pkg::HANDLE_W-1:0]  handle_out,
	output logic [ghp_pkg::DATA_W-1:0]    item_out,
	output logic [1:0]                    status,
	output logic [ghp_pkg::COUNT_W-1:0]   live_count,
	output logic [ghp_pkg::COUNT_W-1:0]   used_count
);
	import ghp_pkg::*;

	localparam int IW  = $clog2(SLOTS);
	localparam int CW  = $clog2(SLOTS + 1);
	localparam int SW  = (ITEM_WIDTH < DATA_W) ? ITEM_WIDTH : DATA_W;
	localparam int XW  = IDX_W + 1;

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_EXEC = 2'b10
	} bk_state_t;

	slot_ent_t          slot_mem [SLOTS];
	logic [SW-1:0]      item_mem [SLOTS];

	bk_state_t          state_q;
	logic [LIMIT_W-1:0] lim_q;
	logic               free_vld_q;
	logic [IW-1:0]      free_idx_q;
	logic [CW-1:0]      live_q;
	logic [CW-1:0]      opened_q;
	logic               out_valid_q;
	req_t               cmd_q;
	slot_ent_t          ent_q;
	logic [SW-1:0]      item_rd_q;
	logic [HANDLE_W-1:0] hout_q;
	logic [DATA_W-1:0]  iout_q;
	logic [1:0]         status_q;

	logic               rd_en;
	logic [IW-1:0]      rd_addr;
	logic               exec;
	logic               hit;
	logic               can_open;
	logic [GEN_W-1:0]   gen_inc;
	logic [GEN_W-1:0]   gen_new;
	logic [XW-1:0]      opened_x;

	logic               wr_slot;
	logic               wr_item;
	logic [IW-1:0]      wr_addr;
	slot_ent_t          wr_ent;
	logic               free_vld_nxt;
	logic [IW-1:0]      free_idx_nxt;
	logic [CW-1:0]      live_nxt;
	logic [CW-1:0]      opened_nxt;
	logic [HANDLE_W-1:0] hout_nxt;
	logic [DATA_W-1:0]  iout_nxt;
	logic [1:0]         status_nxt;

	assign cfg_ready = 1'b1;
	assign req_ready = state_q == BK_IDLE;
	assign rd_en     = req_valid && req_ready;
	assign rd_addr   = (req.kind == OPC_ADD) ? free_idx_q : req.idx[IW-1:0];
	assign exec      = (state_q == BK_EXEC) && (!out_valid_q || out_ready);

	assign opened_x = XW'(opened_q);
	assign hit      = cmd_q.idx_in_range && ({1'b0, cmd_q.idx} < opened_x) &&
	                  !ent_q.inv && (ent_q.gen == cmd_q.gen);
	assign can_open = (opened_x < XW'(lim_q)) && (opened_x < XW'(SLOTS));
	assign gen_inc  = ent_q.gen + 15'd1;
	assign gen_new  = (gen_inc == GEN_WRAP) ? '0 : gen_inc;

	always_comb begin
		wr_slot      = 1'b0;
		wr_item      = 1'b0;
		wr_addr      = cmd_q.idx[IW-1:0];
		wr_ent       = ent_q;
		free_vld_nxt = free_vld_q;
		free_idx_nxt = free_idx_q;
		live_nxt     = live_q;
		opened_nxt   = opened_q;
		hout_nxt     = '0;
		iout_nxt     = '0;
		status_nxt   = ST_OK;
		unique case (cmd_q.kind)
			OPC_ADD: begin
				priority if (free_vld_q) begin
					// reuse the most recently freed slot
					wr_slot      = 1'b1;
					wr_item      = 1'b1;
					wr_addr      = free_idx_q;
					wr_ent.inv   = 1'b0;
					wr_ent.gen   = gen_new;
					wr_ent.link  = IDX_W'(free_idx_q);
					hout_nxt     = {1'b0, gen_new, IDX_W'(free_idx_q)};
					free_vld_nxt = ent_q.link != IDX_NULL;
					free_idx_nxt = ent_q.link[IW-1:0];
					live_nxt     = live_q + CW'(1);
				end else if (can_open) begin
					wr_slot     = 1'b1;
					wr_item     = 1'b1;
					wr_addr     = opened_q[IW-1:0];
					wr_ent.inv  = 1'b0;
					wr_ent.gen  = '0;
					wr_ent.link = IDX_W'(opened_q);
					hout_nxt    = HANDLE_W'(opened_q);
					opened_nxt  = opened_q + CW'(1);
					live_nxt    = live_q + CW'(1);
				end else begin
					hout_nxt   = '1;
					status_nxt = ST_FULL;
				end
			end
			OPC_REMOVE: begin
				if (hit) begin
					// push the slot onto the head of the free list
					wr_slot      = 1'b1;
					wr_ent.inv   = 1'b1;
					wr_ent.gen   = ent_q.gen;
					wr_ent.link  = free_vld_q ? IDX_W'(free_idx_q) : IDX_NULL;
					free_vld_nxt = 1'b1;
					free_idx_nxt = cmd_q.idx[IW-1:0];
					if (live_q != '0) live_nxt = live_q - CW'(1);
				end else begin
					status_nxt = ST_STALE;
				end
			end
			OPC_GET: begin
				if (hit) iout_nxt = DATA_W'(item_rd_q);
				else status_nxt = ST_STALE;
			end
			OPC_NOP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			lim_q       <= LIMIT_RESET;
			free_vld_q  <= 1'b0;
			free_idx_q  <= '0;
			live_q      <= '0;
			opened_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) lim_q <= slot_limit;
			if (exec) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				BK_IDLE: begin
					if (rd_en) state_q <= BK_EXEC;
				end
				BK_EXEC: begin
					if (exec) begin
						state_q     <= BK_IDLE;
						free_vld_q  <= free_vld_nxt;
						free_idx_q  <= free_idx_nxt;
						live_q      <= live_nxt;
						opened_q    <= opened_nxt;
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			cmd_q     <= req;
			ent_q     <= slot_mem[rd_addr];
			item_rd_q <= item_mem[rd_addr];
		end
		if (exec) begin
			hout_q   <= hout_nxt;
			iout_q   <= iout_nxt;
			status_q <= status_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (exec && wr_slot) slot_mem[wr_addr] <= wr_ent;
	end

	always_ff @(posedge clk) begin
		if (exec && wr_item) item_mem[wr_addr] <= cmd_q.data[SW-1:0];
	end

	assign out_valid  = out_valid_q;
	assign handle_out = hout_q;
	assign item_out   = iout_q;
	assign status     = status_q;
	assign live_count = COUNT_W'(live_q);
	assign used_count = COUNT_W'(opened_q);

endmodule

FILE: rtl/generational_handle_pool.sv
// Top level of the generational handle pool: front decode queue plus back end.
// Depends on ghp_pkg, ghp_front and ghp_back.
//
// Hands out 32-bit handles (index in bits 15:0, generation in 30:16) for stored
// items, and checks handles on remove and get. Requests queue two deep in the
// front; the back end handles each as a slot table read then its write-back, and
// takes no new request until that write-back is done. A result waits in an
// output register while the queue keeps taking requests. The slot table needs
// no clearing pass: entries at or above the high-water mark may be read but are
// never used. slot_limit is written through its own channel and must only
// change while the pool is idle.
module generational_handle_pool #(
	parameter int SLOTS      = ghp_pkg::SLOTS_DEF,
	parameter int ITEM_WIDTH = ghp_pkg::ITEM_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ghp_pkg::LIMIT_W-1:0]   slot_limit,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    opcode,
	input  logic [ghp_pkg::HANDLE_W-1:0]  handle_in,
	input  logic [ghp_pkg::DATA_W-1:0]    item_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ghp_pkg::HANDLE_W-1:0]  handle_out,
	output logic [ghp_pkg::DATA_W-1:0]    item_out,
	output logic [1:0]                    status,
	output logic [ghp_pkg::COUNT_W-1:0]   live_count,
	output logic [ghp_pkg::COUNT_W-1:0]   used_count
);
	import ghp_pkg::*;

	logic req_valid;
	logic req_ready;
	req_t req;

	ghp_front #(
		.SLOTS(SLOTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.handle_in (handle_in),
		.item_data (item_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req)
	);

	ghp_back #(
		.SLOTS      (SLOTS),
		.ITEM_WIDTH (ITEM_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.slot_limit (slot_limit),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.handle_out (handle_out),
		.item_out   (item_out),
		.status     (status),
		.live_count (live_count),
		.used_count (used_count)
	);

	a_full_null: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> handle_out == '1)
		else $error("full pool result without null handle");

	a_stale_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_STALE |-> handle_out == '0 && item_out == '0)
		else $error("rejected handle result carries data");

	a_ok_valid_handle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> !handle_out[31])
		else $error("successful result carries invalid handle");

	a_req_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("back end took two requests in consecutive cycles");

endmodule
